// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file rpc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a delay given by the argument n.
`define RPC_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

// ===== rtl/rpc_pkg.sv =====
package rpc_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN = 24;
    localparam int SQRT_STEPS = 16;

    // Coordinate datapath carries 16 extra fraction bits, angles are radians * 2^30.
    localparam int CW = 36;
    localparam int ZW = 35;
    localparam int SW = 32;
    localparam int KPW = 45;
    localparam int ANG_LSB = 17;

    localparam logic signed [ZW-1:0] PI30 = 35'sd3373259426;
    localparam logic signed [ZW-1:0] TWO_PI30 = 35'sd6746518852;
    localparam logic signed [ZW-1:0] HALF_PI30 = 35'sd1686629713;
    localparam logic signed [ZW-1:0] ANG_ROUND = 35'sd65536;
    localparam logic [29:0] INV_GAIN30 = 30'd652032874;

    localparam logic [31:0] ATAN_LUT [TABLE_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef struct packed {
        logic                 polar;
        logic                 zero;
        logic signed [15:0]   a;
        logic signed [15:0]   b;
        logic signed [15:0]   pang;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [SW-1:0]        rem;
        logic [SW-1:0]        root;
    } cell_data_t;

    // Rotation iterations run in the first stages, root bits in the first SQRT_STEPS.
    function automatic int rot_count(input int stages);
        return (stages > TABLE_LEN) ? TABLE_LEN : stages;
    endfunction

    function automatic int cell_count(input int stages);
        return (rot_count(stages) > SQRT_STEPS) ? rot_count(stages) : SQRT_STEPS;
    endfunction

endpackage

// ===== rtl/rpc_front.sv =====
module rpc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                operation,
    input  logic signed [15:0]  first_operand,
    input  logic signed [15:0]  second_operand,
    output logic                out_valid,
    output rpc_pkg::cell_data_t out_data
);

    localparam int CW = rpc_pkg::CW;
    localparam int ZW = rpc_pkg::ZW;
    localparam int SW = rpc_pkg::SW;
    localparam int KPW = rpc_pkg::KPW;
    localparam int ALSB = rpc_pkg::ANG_LSB;

    // First stage: squares, gain-compensated magnitude and angle reduction.
    logic                p1_valid_reg;
    logic                p1_polar_reg;
    logic                p1_zero_reg;
    logic signed [15:0]  p1_a_reg;
    logic signed [15:0]  p1_b_reg;
    logic [SW-1:0]       p1_sqa_reg;
    logic [SW-1:0]       p1_sqb_reg;
    logic [KPW-1:0]      p1_kprod_reg;
    logic signed [ZW-1:0] p1_z_reg;

    logic signed [SW-1:0] sqa_full;
    logic signed [SW-1:0] sqb_full;
    logic [14:0]          mag_in;
    logic [KPW-1:0]       kprod_next;
    logic signed [ZW-1:0] z0;
    logic signed [ZW-1:0] z_next;

    assign sqa_full = first_operand * first_operand;
    assign sqb_full = second_operand * second_operand;
    assign mag_in = first_operand[15] ? 15'd0 : first_operand[14:0];
    assign kprod_next = KPW'(mag_in) * KPW'(rpc_pkg::INV_GAIN30);
    assign z0 = ZW'(second_operand) <<< 17;

    always_comb
    begin
        if (z0 > rpc_pkg::PI30)
        begin
            z_next = z0 - rpc_pkg::TWO_PI30;
        end
        else if (z0 < -rpc_pkg::PI30)
        begin
            z_next = z0 + rpc_pkg::TWO_PI30;
        end
        else
        begin
            z_next = z0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_polar_reg <= operation;
        p1_zero_reg  <= (first_operand == 16'sd0) && (second_operand == 16'sd0);
        p1_a_reg     <= first_operand;
        p1_b_reg     <= second_operand;
        p1_sqa_reg   <= sqa_full;
        p1_sqb_reg   <= sqb_full;
        p1_kprod_reg <= kprod_next;
        p1_z_reg     <= z_next;
    end

    // Second stage: quadrant fold into the CORDIC convergence range, sum of squares and rounded polar angle.
    logic                p2_valid_reg;
    rpc_pkg::cell_data_t p2_data_reg;
    rpc_pkg::cell_data_t p2_next;

    logic signed [CW-1:0] k;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] bx;
    logic signed [ZW-1:0] zr;

    assign k  = CW'(p1_kprod_reg[KPW-1:14]);
    assign ax = CW'(p1_a_reg) <<< 16;
    assign bx = CW'(p1_b_reg) <<< 16;
    assign zr = p1_z_reg + rpc_pkg::ANG_ROUND;

    always_comb
    begin
        p2_next.polar = p1_polar_reg;
        p2_next.zero  = p1_zero_reg;
        p2_next.a     = p1_a_reg;
        p2_next.b     = p1_b_reg;
        p2_next.pang  = zr[ALSB+15:ALSB];
        p2_next.rem   = p1_sqa_reg + p1_sqb_reg;
        p2_next.root  = '0;
        if (p1_polar_reg)
        begin
            p2_next.x = k;
            p2_next.y = '0;
            p2_next.z = p1_z_reg;
            if (p1_z_reg > rpc_pkg::HALF_PI30)
            begin
                p2_next.x = '0;
                p2_next.y = k;
                p2_next.z = p1_z_reg - rpc_pkg::HALF_PI30;
            end
            else if (p1_z_reg < -rpc_pkg::HALF_PI30)
            begin
                p2_next.x = '0;
                p2_next.y = -k;
                p2_next.z = p1_z_reg + rpc_pkg::HALF_PI30;
            end
        end
        else
        begin
            p2_next.x = ax;
            p2_next.y = bx;
            p2_next.z = '0;
            // Vectors in the left half plane are turned by a quarter turn first.
            if (p1_a_reg[15])
            begin
                if (!p1_b_reg[15])
                begin
                    p2_next.x = bx;
                    p2_next.y = -ax;
                    p2_next.z = rpc_pkg::HALF_PI30;
                end
                else
                begin
                    p2_next.x = -bx;
                    p2_next.y = ax;
                    p2_next.z = -rpc_pkg::HALF_PI30;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_data_reg <= p2_next;
    end

    assign out_valid = p2_valid_reg;
    assign out_data  = p2_data_reg;

endmodule

// ===== rtl/rpc_cell.sv =====
module rpc_cell #(
    parameter int ITER   = 0,
    parameter int STAGES = rpc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rpc_pkg::cell_data_t in_data,
    output logic                out_valid,
    output rpc_pkg::cell_data_t out_data
);

    localparam int CW = rpc_pkg::CW;
    localparam int ZW = rpc_pkg::ZW;
    localparam int SW = rpc_pkg::SW;
    localparam bit DO_ROT = ITER < rpc_pkg::rot_count(STAGES);
    localparam bit DO_SQRT = ITER < rpc_pkg::SQRT_STEPS;
    localparam logic signed [ZW-1:0] ATAN_Z = ZW'(rpc_pkg::ATAN_LUT[DO_ROT ? ITER : 0]);
    localparam int SQ_SH = DO_SQRT ? 2 * (rpc_pkg::SQRT_STEPS - 1 - ITER) : 0;
    localparam logic [SW-1:0] SQ_BIT = SW'(1) << SQ_SH;

    logic                valid_reg;
    rpc_pkg::cell_data_t data_reg;
    rpc_pkg::cell_data_t data_next;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 ccw;
    logic [SW:0]          trial;

    always_comb
    begin
        data_next = in_data;
        dx = $signed(in_data.y) >>> ITER;
        dy = $signed(in_data.x) >>> ITER;
        // Rotation drives the residual angle to zero, vectoring drives y to zero.
        ccw = in_data.polar ? !in_data.z[ZW-1] : (in_data.y[CW-1] || (in_data.y == '0));
        trial = {1'b0, in_data.root} + {1'b0, SQ_BIT};
        if (DO_ROT)
        begin
            if (ccw)
            begin
                data_next.x = $signed(in_data.x) - dx;
                data_next.y = $signed(in_data.y) + dy;
                data_next.z = $signed(in_data.z) - ATAN_Z;
            end
            else
            begin
                data_next.x = $signed(in_data.x) + dx;
                data_next.y = $signed(in_data.y) - dy;
                data_next.z = $signed(in_data.z) + ATAN_Z;
            end
        end
        if (DO_SQRT)
        begin
            if ({1'b0, in_data.rem} >= trial)
            begin
                data_next.rem  = in_data.rem - trial[SW-1:0];
                data_next.root = (in_data.root >> 1) + SQ_BIT;
            end
            else
            begin
                data_next.root = in_data.root >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/rpc_back.sv =====
module rpc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rpc_pkg::cell_data_t in_data,
    output logic                done,
    output logic signed [15:0]  x_coord,
    output logic signed [15:0]  y_coord,
    output logic [15:0]         magnitude,
    output logic signed [15:0]  angle
);

    localparam int CW = rpc_pkg::CW;
    localparam int ZW = rpc_pkg::ZW;
    localparam int ALSB = rpc_pkg::ANG_LSB;
    localparam logic signed [CW-1:0] COORD_ROUND = 36'sd32768;

    function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] s;
        begin
            s = (v + COORD_ROUND) >>> 16;
            if (s > 36'sd32767)
            begin
                sat16 = 16'sh7FFF;
            end
            else if (s < -36'sd32768)
            begin
                sat16 = 16'sh8000;
            end
            else
            begin
                sat16 = s[15:0];
            end
        end
    endfunction

    logic                done_reg;
    logic signed [15:0]  x_reg;
    logic signed [15:0]  y_reg;
    logic [15:0]         mag_reg;
    logic signed [15:0]  ang_reg;

    logic signed [15:0]  x_next;
    logic signed [15:0]  y_next;
    logic [15:0]         mag_next;
    logic signed [15:0]  ang_next;
    logic signed [ZW-1:0] za;
    logic [15:0]         root_rnd;

    assign za = $signed(in_data.z) + rpc_pkg::ANG_ROUND;
    // The root rounds up when the remainder passes the truncated root.
    assign root_rnd = in_data.root[15:0] + 16'(in_data.rem > in_data.root);

    always_comb
    begin
        if (in_data.polar)
        begin
            x_next   = sat16(in_data.x);
            y_next   = sat16(in_data.y);
            mag_next = in_data.a[15] ? 16'd0 : in_data.a;
            ang_next = in_data.pang;
        end
        else
        begin
            x_next   = in_data.a;
            y_next   = in_data.b;
            mag_next = root_rnd;
            ang_next = in_data.zero ? 16'sd0 : za[ALSB+15:ALSB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        mag_reg <= mag_next;
        ang_reg <= ang_next;
    end

    assign done      = done_reg;
    assign x_coord   = x_reg;
    assign y_coord   = y_reg;
    assign magnitude = mag_reg;
    assign angle     = ang_reg;

endmodule

// ===== rtl/rect_polar_converter_unit.sv =====
// A request passes the front stages, the cell chain and the output register, then done pulses.
// Throughput: one request per cycle; busy stays low and the pipeline never holds.
// The rate is set by the cell chain: at most one CORDIC iteration and one root bit per cell and cycle.
// Results are shown for one cycle only; the receiver cannot stall them.
// Reset (rst_n, asynchronous, active low) clears the valid bit of every stage.
module rect_polar_converter_unit #(
    parameter int CORDIC_STAGES = rpc_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic signed [15:0] first_operand,
    input  logic signed [15:0] second_operand,
    output logic               done,
    output logic signed [15:0] x_coord,
    output logic signed [15:0] y_coord,
    output logic [15:0]        magnitude,
    output logic signed [15:0] angle
);

    localparam int CELLS = rpc_pkg::cell_count(CORDIC_STAGES);

    logic [CELLS:0]      valid_chain;
    rpc_pkg::cell_data_t data_chain [CELLS+1];

    assign busy = 1'b0;

    rpc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (start && !busy),
        .operation      (operation),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .out_valid      (valid_chain[0]),
        .out_data       (data_chain[0])
    );

    genvar i;
    generate
        for (i = 0; i < CELLS; i++)
        begin : g_cell
            rpc_cell #(
                .ITER   (i),
                .STAGES (CORDIC_STAGES)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (valid_chain[i]),
                .in_data   (data_chain[i]),
                .out_valid (valid_chain[i+1]),
                .out_data  (data_chain[i+1])
            );
        end
    endgenerate

    rpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_chain[CELLS]),
        .in_data   (data_chain[CELLS]),
        .done      (done),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .magnitude (magnitude),
        .angle     (angle)
    );

endmodule

// ===== rtl/rpc_checker.sv =====
`include "assert_macros.svh"

module rpc_checker #(
    parameter int CORDIC_STAGES = rpc_pkg::CORDIC_STAGES_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               operation,
    input logic signed [15:0] first_operand,
    input logic signed [15:0] second_operand,
    input logic               done,
    input logic signed [15:0] x_coord,
    input logic signed [15:0] y_coord,
    input logic [15:0]        magnitude,
    input logic signed [15:0] angle
);

    localparam int LAT = rpc_pkg::cell_count(CORDIC_STAGES) + 3;

    logic req;
    assign req = start && !busy && rst_n;

    `RPC_ASSERT_DELAY(a_req_done, clk, rst_n, req, LAT, done, "request did not complete in time")

    `RPC_ASSERT_IMP(a_done_req, clk, rst_n, done, $past(req, LAT), "result without a request")

    `RPC_ASSERT_IMP(a_rect_pass, clk, rst_n, done && $past(req && !operation, LAT), (x_coord == $past(first_operand, LAT)) && (y_coord == $past(second_operand, LAT)), "rectangular operands not returned")

    `RPC_ASSERT_IMP(a_polar_mag, clk, rst_n, done && $past(req && operation, LAT), magnitude == ($past(first_operand[15], LAT) ? 16'd0 : $past(first_operand, LAT)), "polar magnitude not returned")

    `RPC_ASSERT_IMP(a_zero_vec, clk, rst_n, done && $past(req && !operation && (first_operand == 16'sd0) && (second_operand == 16'sd0), LAT), (angle == 16'sd0) && (magnitude == 16'd0), "zero vector result not zero")

endmodule

bind rect_polar_converter_unit rpc_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_rpc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .done           (done),
    .x_coord        (x_coord),
    .y_coord        (y_coord),
    .magnitude      (magnitude),
    .angle          (angle)
);

// ===== tb/tb_rect_polar_converter_unit.sv =====
module tb_rect_polar_converter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CORDIC_STAGES = 16;
    localparam int STAGES_USED = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
    localparam int PIPE_LATENCY = ((CORDIC_STAGES > 16) ? CORDIC_STAGES : 16) + 3;
    localparam int RANDOM_REQUESTS = 450;

    localparam bit OP_RECT_TO_POLAR = 1'b0;
    localparam bit OP_POLAR_TO_RECT = 1'b1;

    // Angles in the CORDIC path are radians scaled by 2^30.
    localparam longint RAD30_PI = 64'sd3373259426;
    localparam longint RAD30_TWO_PI = 64'sd6746518852;
    localparam longint RAD30_HALF_PI = 64'sd1686629713;
    localparam longint CORDIC_INV_GAIN = 64'sd652032874;
    localparam longint ATAN_RAD30 [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    // Q2.13 angle codes used by the directed tests.
    localparam logic signed [15:0] ANG_PI = 16'sd25736;
    localparam logic signed [15:0] ANG_HALF_PI = 16'sd12868;
    localparam logic signed [15:0] ANG_QUARTER_PI = 16'sd6434;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        mag;
        logic signed [15:0] ang;
    } coord_set_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               operation;
    logic signed [15:0] first_operand;
    logic signed [15:0] second_operand;
    logic               done;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic [15:0]        magnitude;
    logic signed [15:0] angle;

    coord_set_t pending_coords[$];
    int         mismatch_count;
    bit         burst_mode;

    rect_polar_converter_unit #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .first_operand(first_operand),
        .second_operand(second_operand),
        .done(done),
        .x_coord(x_coord),
        .y_coord(y_coord),
        .magnitude(magnitude),
        .angle(angle)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_rect_polar_converter_unit: FAIL");
        $finish;
    end

    function automatic longint unsigned rounded_sqrt(longint unsigned s);
        longint unsigned root;
        longint unsigned probe;
        longint unsigned rest;
        root = 0;
        probe = 64'h4000_0000_0000_0000;
        rest = s;
        while (probe > rest)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest -= root + probe;
                root = (root >> 1) + probe;
            end
            else
            begin
                root >>= 1;
            end
            probe >>= 2;
        end
        if (rest > root)
            root++;
        return root;
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint vectoring_angle(longint xi, longint yi);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        x = xi * 65536;
        y = yi * 65536;
        z = 0;
        // Fold the left half plane into the CORDIC convergence range.
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = RAD30_HALF_PI;
            end
            else
            begin
                x = -y;
                y = t;
                z = -RAD30_HALF_PI;
            end
        end
        for (int i = 0; i < STAGES_USED; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += ATAN_RAD30[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= ATAN_RAD30[i];
            end
        end
        return (z + 65536) >>> 17;
    endfunction

    function automatic coord_set_t convert_coords(bit op, logic signed [15:0] a,
                                                  logic signed [15:0] b);
        coord_set_t res;
        longint av;
        longint bv;
        longint mag;
        longint z;
        longint x;
        longint y;
        longint k;
        longint dx;
        longint dy;
        av = a;
        bv = b;
        if (op == OP_RECT_TO_POLAR)
        begin
            res.x = a;
            res.y = b;
            res.mag = 16'(rounded_sqrt(longint'(av * av + bv * bv)));
            res.ang = (av == 0 && bv == 0) ? 16'sd0 : 16'(vectoring_angle(av, bv));
        end
        else
        begin
            mag = (av < 0) ? 0 : av;
            z = bv * 131072;
            if (z > RAD30_PI)
                z -= RAD30_TWO_PI;
            if (z < -RAD30_PI)
                z += RAD30_TWO_PI;
            res.ang = 16'((z + 65536) >>> 17);
            k = (mag * CORDIC_INV_GAIN) >>> 14;
            x = k;
            y = 0;
            if (z > RAD30_HALF_PI)
            begin
                x = 0;
                y = k;
                z -= RAD30_HALF_PI;
            end
            else if (z < -RAD30_HALF_PI)
            begin
                x = 0;
                y = -k;
                z += RAD30_HALF_PI;
            end
            for (int i = 0; i < STAGES_USED; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= ATAN_RAD30[i];
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += ATAN_RAD30[i];
                end
            end
            res.x = 16'(sat16((x + 32768) >>> 16));
            res.y = 16'(sat16((y + 32768) >>> 16));
            res.mag = 16'(mag);
        end
        return res;
    endfunction

    // Predict at the edge where the request is taken; inputs are stable since the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            pending_coords.push_back(convert_coords(operation, first_operand, second_operand));
    end

    always @(posedge clk)
    begin
        coord_set_t exp_c;
        if (rst_n && done)
        begin
            if (pending_coords.size() == 0)
            begin
                $error("result with no request outstanding: x=%0d y=%0d mag=%0d ang=%0d",
                       x_coord, y_coord, magnitude, angle);
                mismatch_count++;
            end
            else
            begin
                exp_c = pending_coords.pop_front();
                if (x_coord !== exp_c.x)
                begin
                    $error("x_coord: expected %0d, got %0d", exp_c.x, x_coord);
                    mismatch_count++;
                end
                if (y_coord !== exp_c.y)
                begin
                    $error("y_coord: expected %0d, got %0d", exp_c.y, y_coord);
                    mismatch_count++;
                end
                if (magnitude !== exp_c.mag)
                begin
                    $error("magnitude: expected %0d, got %0d", exp_c.mag, magnitude);
                    mismatch_count++;
                end
                if (angle !== exp_c.ang)
                begin
                    $error("angle: expected %0d, got %0d", exp_c.ang, angle);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_request(bit op, logic signed [15:0] a, logic signed [15:0] b);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        operation = op;
        first_operand = a;
        second_operand = b;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic test_rect_extremes();
        send_request(OP_RECT_TO_POLAR, 16'sd0, 16'sd0);
        send_request(OP_RECT_TO_POLAR, 16'sd32767, 16'sd32767);
        send_request(OP_RECT_TO_POLAR, -16'sd32768, -16'sd32768);
        send_request(OP_RECT_TO_POLAR, -16'sd32768, 16'sd0);
        send_request(OP_RECT_TO_POLAR, 16'sd0, -16'sd32768);
        send_request(OP_RECT_TO_POLAR, 16'sd32767, -16'sd32768);
        send_request(OP_RECT_TO_POLAR, -16'sd32768, 16'sd32767);
        send_request(OP_RECT_TO_POLAR, -16'sd1, 16'sd0);
        send_request(OP_RECT_TO_POLAR, 16'sd1, 16'sd0);
        send_request(OP_RECT_TO_POLAR, 16'sd0, 16'sd1);
    endtask

    task automatic test_polar_negative_magnitude();
        send_request(OP_POLAR_TO_RECT, -16'sd32768, 16'sd1000);
        send_request(OP_POLAR_TO_RECT, -16'sd1, -16'sd5000);
    endtask

    task automatic test_polar_angle_wrap();
        send_request(OP_POLAR_TO_RECT, 16'sd256, 16'sd32767);
        send_request(OP_POLAR_TO_RECT, 16'sd256, -16'sd32768);
        send_request(OP_POLAR_TO_RECT, 16'sd1000, ANG_PI);
        send_request(OP_POLAR_TO_RECT, 16'sd1000, -ANG_PI);
        send_request(OP_POLAR_TO_RECT, 16'sd1000, ANG_PI + 16'sd1);
    endtask

    // Full-scale magnitudes on the axes probe coordinate saturation.
    task automatic test_polar_quadrants();
        send_request(OP_POLAR_TO_RECT, 16'sd32767, 16'sd0);
        send_request(OP_POLAR_TO_RECT, 16'sd32767, ANG_HALF_PI);
        send_request(OP_POLAR_TO_RECT, 16'sd32767, -ANG_HALF_PI);
        send_request(OP_POLAR_TO_RECT, 16'sd32767, ANG_PI);
        send_request(OP_POLAR_TO_RECT, 16'sd32767, ANG_QUARTER_PI);
        send_request(OP_POLAR_TO_RECT, 16'sd0, ANG_QUARTER_PI);
        send_request(OP_POLAR_TO_RECT, 16'sd32767, -ANG_HALF_PI - ANG_QUARTER_PI);
    endtask

    task automatic test_random_conversions();
        bit                 op;
        logic signed [15:0] a;
        logic signed [15:0] b;
        int                 kind;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 40 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            op = 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 9);
            if (op == OP_RECT_TO_POLAR)
            begin
                if (kind < 6)
                begin
                    a = 16'($urandom);
                    b = 16'($urandom);
                end
                else if (kind < 9)
                begin
                    a = $signed(16'($urandom_range(0, 512))) - 16'sd256;
                    b = $signed(16'($urandom_range(0, 512))) - 16'sd256;
                end
                else
                begin
                    a = ($urandom_range(0, 1) != 0) ? 16'sd0 : 16'($urandom);
                    b = ($urandom_range(0, 1) != 0) ? 16'sd0 : 16'($urandom);
                end
            end
            else
            begin
                a = (kind == 0) ? 16'($urandom) : 16'($urandom_range(0, 32767));
                if (kind < 8)
                    b = $signed(16'($urandom_range(0, 2 * 25736))) - ANG_PI;
                else
                    b = 16'($urandom);
            end
            send_request(op, a, b);
        end
        @(negedge clk);
        start = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_RECT_TO_POLAR;
        first_operand = '0;
        second_operand = '0;
        mismatch_count = 0;
        burst_mode = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_rect_extremes();
        test_polar_negative_magnitude();
        test_polar_angle_wrap();
        test_polar_quadrants();
        test_random_conversions();

        wait (pending_coords.size() == 0);
        repeat (PIPE_LATENCY + 5) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_rect_polar_converter_unit: PASS");
        else
            $display("tb_rect_polar_converter_unit: FAIL");
        $finish;
    end

endmodule
